// ----- sv/sdeg_pkg.sv -----
// Shared types and constants for the slewed downward expander gate.
// No dependencies; used by the controller, the datapath and the top level.
package sdeg_pkg;

  localparam int CHANNELS_DEF    = 2;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_BITS     = 24;
  localparam int TRIM_W       = 16;
  localparam int THR_W        = 23;
  localparam int COEF_W       = 24;
  localparam int GAIN_W       = 25;
  localparam int FRAC         = 24;
  localparam int TRIM_FRAC    = 12;
  localparam int DIV_STEPS    = 24;
  localparam int CNT_W        = 5;
  localparam int MB_W         = 26;

  localparam logic [TRIM_W-1:0] TRIM_RST    = 16'd4096;
  localparam logic [THR_W-1:0]  THR_RST     = 23'd26527;
  localparam logic [COEF_W-1:0] ATTACK_RST  = 24'd345960;
  localparam logic [COEF_W-1:0] RELEASE_RST = 24'd29090;
  localparam logic [COEF_W-1:0] SLEW_RST    = 24'd87160;
  localparam logic [GAIN_W-1:0] UNITY_GAIN  = 25'h100_0000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRIM    = 3'd0,
    REG_THR     = 3'd1,
    REG_ATTACK  = 3'd2,
    REG_RELEASE = 3'd3,
    REG_SLEW    = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TRIM, ST_SAT, ST_DIFF, ST_ENVMUL, ST_ENVUPD, ST_CMP, ST_DIV,
    ST_SQ1, ST_R2, ST_SQ2, ST_TGT, ST_GDIFF, ST_SLEW, ST_GUPD, ST_OUTMUL, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TRIM, OP_SAT, OP_DIFF, OP_ENVMUL, OP_ENVUPD, OP_CMP,
    OP_DIV, OP_SQ1, OP_R2, OP_SQ2, OP_TGT, OP_GDIFF, OP_SLEW, OP_GUPD,
    OP_OUTMUL, OP_EMIT
  } op_t;

  typedef struct packed {
    logic ge_thr;    // envelope at or above threshold
    logic out_free;  // output register can take a result
  } sdeg_sts_t;

endpackage

// ----- sv/sdeg_ctrl.sv -----
// Sequencer of the gate: steps one sample through the shared datapath.
// Depends on sdeg_pkg for state, command and status types.
module sdeg_ctrl
  import sdeg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  sdeg_sts_t sts,
  output op_t       cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_TRIM;
      ST_TRIM:   state_nxt = ST_SAT;
      ST_SAT:    state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_ENVMUL;
      ST_ENVMUL: state_nxt = ST_ENVUPD;
      ST_ENVUPD: state_nxt = ST_CMP;
      ST_CMP: begin
        div_cnt_nxt = '0;
        state_nxt   = sts.ge_thr ? ST_GDIFF : ST_DIV;
      end
      ST_DIV: begin
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_SQ1;
      end
      ST_SQ1:    state_nxt = ST_R2;
      ST_R2:     state_nxt = ST_SQ2;
      ST_SQ2:    state_nxt = ST_TGT;
      ST_TGT:    state_nxt = ST_GDIFF;
      ST_GDIFF:  state_nxt = ST_SLEW;
      ST_SLEW:   state_nxt = ST_GUPD;
      ST_GUPD:   state_nxt = ST_OUTMUL;
      ST_OUTMUL: state_nxt = ST_FIN;
      ST_FIN:    if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = OP_LOAD;
      end
      ST_TRIM:   cmd = OP_TRIM;
      ST_SAT:    cmd = OP_SAT;
      ST_DIFF:   cmd = OP_DIFF;
      ST_ENVMUL: cmd = OP_ENVMUL;
      ST_ENVUPD: cmd = OP_ENVUPD;
      ST_CMP:    cmd = OP_CMP;
      ST_DIV:    cmd = OP_DIV;
      ST_SQ1:    cmd = OP_SQ1;
      ST_R2:     cmd = OP_R2;
      ST_SQ2:    cmd = OP_SQ2;
      ST_TGT:    cmd = OP_TGT;
      ST_GDIFF:  cmd = OP_GDIFF;
      ST_SLEW:   cmd = OP_SLEW;
      ST_GUPD:   cmd = OP_GUPD;
      ST_OUTMUL: cmd = OP_OUTMUL;
      ST_FIN:    if (sts.out_free) cmd = OP_EMIT;
      default:   cmd = OP_NONE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_TRIM))
    else $error("accepted sample did not start processing");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divide step count out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_EMIT) |-> sts.out_free)
    else $error("result emitted over an unread output");

  a_one_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_EMIT) |=> (state_r == ST_IDLE))
    else $error("emit did not return to idle");

endmodule

// ----- sv/sdeg_dp.sv -----
// Datapath of the gate: config registers, per-channel state, one shared
// multiplier, a radix-2 restoring divider and the output register.
// Depends on sdeg_pkg; driven by commands from sdeg_ctrl.
module sdeg_dp
  import sdeg_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  op_t                           cmd,
  output sdeg_sts_t                     sts,
  input  logic                          in_chan,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_chan,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  localparam int SB  = SAMPLE_BITS;
  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DW  = (SB > GAIN_W) ? SB : GAIN_W;
  localparam int AW  = DW + 1;
  localparam int PW  = AW + MB_W;
  localparam int CW  = (SB > THR_W) ? SB : THR_W;

  localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 <<< (FRAC - 1));
  localparam logic signed [PW-1:0] TRIM_HALF_P = PW'(64'sd1 <<< (TRIM_FRAC - 1));
  localparam logic signed [PW-1:0] SAT_HI =
    {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO =
    {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  // configuration
  logic [TRIM_W-1:0] trim_r;
  logic [THR_W-1:0]  thr_r;
  logic [COEF_W-1:0] attack_r, release_r, slew_r;

  // per-channel state
  logic [SB-1:0]     env_mem [CHANNELS];
  logic [GAIN_W-1:0] gg_mem  [CHANNELS];

  // working registers
  logic                 chan_r;
  logic [CIW-1:0]       idx_r;
  logic signed [SB-1:0] smp_r, x_r;
  logic [SB-1:0]        mag_r, env_r;
  logic [GAIN_W-1:0]    gg_r, t_r, target_r;
  logic [DW-1:0]        d_r;
  logic                 up_r, sel_att_r;
  logic signed [PW-1:0] prod_r;
  logic [FRAC-1:0]      q_r;
  logic [THR_W-1:0]     rem_r;
  logic                 out_valid_r, out_chan_r;
  logic signed [SB-1:0] out_smp_r;

  logic signed [AW-1:0]   ma;
  logic signed [MB_W-1:0] mb;
  logic signed [PW-1:0]   mul, rnd_full, trim_full;
  logic signed [SB-1:0]   x_sat, y_sat;
  logic signed [SB:0]     x_ext;
  logic [SB-1:0]          mag_nxt, env_nxt;
  logic [GAIN_W-1:0]      gg_nxt;
  logic [THR_W-1:0]       thr_eff;
  logic [THR_W+1:0]       trial;
  logic [CIW-1:0]         in_idx;

  assign cfg_ready = 1'b1;
  assign thr_eff   = (thr_r == '0) ? THR_W'(1) : thr_r;
  assign in_idx    = (CHANNELS > 1) ? CIW'(in_chan) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r    <= TRIM_RST;
      thr_r     <= THR_RST;
      attack_r  <= ATTACK_RST;
      release_r <= RELEASE_RST;
      slew_r    <= SLEW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRIM:    trim_r    <= cfg_data[TRIM_W-1:0];
        REG_THR:     thr_r     <= cfg_data[THR_W-1:0];
        REG_ATTACK:  attack_r  <= cfg_data[COEF_W-1:0];
        REG_RELEASE: release_r <= cfg_data[COEF_W-1:0];
        REG_SLEW:    slew_r    <= cfg_data[COEF_W-1:0];
        default:     ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd)
      OP_TRIM: begin
        ma = AW'(smp_r);
        mb = {{(MB_W-TRIM_W){1'b0}}, trim_r};
      end
      OP_ENVMUL: begin
        ma = {1'b0, d_r};
        mb = {{(MB_W-COEF_W){1'b0}}, (sel_att_r ? attack_r : release_r)};
      end
      OP_SQ1: begin
        ma = {{(AW-FRAC){1'b0}}, q_r};
        mb = {{(MB_W-FRAC){1'b0}}, q_r};
      end
      OP_SQ2: begin
        ma = {{(AW-GAIN_W){1'b0}}, t_r};
        mb = {{(MB_W-GAIN_W){1'b0}}, t_r};
      end
      OP_SLEW: begin
        ma = {1'b0, d_r};
        mb = {{(MB_W-COEF_W){1'b0}}, slew_r};
      end
      OP_OUTMUL: begin
        ma = AW'(x_r);
        mb = {{(MB_W-GAIN_W){1'b0}}, gg_r};
      end
      default: ;
    endcase
  end

  assign mul       = ma * mb;
  assign rnd_full  = (prod_r + HALF_P) >>> FRAC;
  assign trim_full = (prod_r + TRIM_HALF_P) >>> TRIM_FRAC;

  always_comb begin
    priority if (trim_full > SAT_HI) x_sat = SAT_HI[SB-1:0];
    else if (trim_full < SAT_LO)     x_sat = SAT_LO[SB-1:0];
    else                             x_sat = trim_full[SB-1:0];
    priority if (rnd_full > SAT_HI)  y_sat = SAT_HI[SB-1:0];
    else if (rnd_full < SAT_LO)      y_sat = SAT_LO[SB-1:0];
    else                             y_sat = rnd_full[SB-1:0];
  end

  // the most negative sample keeps its full magnitude in SB unsigned bits
  assign x_ext   = (SB+1)'(x_sat);
  assign mag_nxt = x_sat[SB-1] ? SB'(-x_ext) : SB'(x_ext);
  assign env_nxt = up_r ? (env_r + rnd_full[SB-1:0]) : (env_r - rnd_full[SB-1:0]);
  assign gg_nxt  = up_r ? (gg_r + rnd_full[GAIN_W-1:0])
                        : (gg_r - rnd_full[GAIN_W-1:0]);
  assign trial   = {1'b0, rem_r, 1'b0} - {2'b00, thr_eff};

  assign sts.ge_thr   = CW'(env_r) >= CW'(thr_eff);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        env_mem[i] <= '0;
        gg_mem[i]  <= '0;
      end
    end else if (cmd == OP_ENVUPD) begin
      env_mem[idx_r] <= env_nxt;
    end else if (cmd == OP_GUPD) begin
      gg_mem[idx_r] <= gg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      OP_LOAD: begin
        chan_r <= in_chan;
        idx_r  <= in_idx;
        smp_r  <= in_sample;
        env_r  <= env_mem[in_idx];
        gg_r   <= gg_mem[in_idx];
      end
      OP_TRIM, OP_ENVMUL, OP_SQ1, OP_SQ2, OP_SLEW, OP_OUTMUL: prod_r <= mul;
      OP_SAT: begin
        x_r   <= x_sat;
        mag_r <= mag_nxt;
      end
      OP_DIFF: begin
        up_r      <= mag_r >= env_r;
        sel_att_r <= mag_r > env_r;
        d_r       <= DW'((mag_r >= env_r) ? (mag_r - env_r) : (env_r - mag_r));
      end
      OP_ENVUPD: env_r <= env_nxt;
      OP_CMP: begin
        target_r <= UNITY_GAIN;
        rem_r    <= env_r[THR_W-1:0];
        q_r      <= '0;
      end
      OP_DIV: begin
        if (!trial[THR_W+1]) begin
          rem_r <= trial[THR_W-1:0];
          q_r   <= {q_r[FRAC-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[THR_W-2:0], 1'b0};
          q_r   <= {q_r[FRAC-2:0], 1'b0};
        end
      end
      OP_R2:  t_r      <= rnd_full[GAIN_W-1:0];
      OP_TGT: target_r <= rnd_full[GAIN_W-1:0];
      OP_GDIFF: begin
        up_r <= target_r >= gg_r;
        d_r  <= DW'((target_r >= gg_r) ? (target_r - gg_r) : (gg_r - target_r));
      end
      OP_GUPD: gg_r <= gg_nxt;
      OP_EMIT: begin
        out_chan_r <= chan_r;
        out_smp_r  <= y_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_chan   = out_chan_r;
  assign out_sample = out_smp_r;

endmodule

// ----- sv/slewed_downward_expander_gate.sv -----
// Slewed downward expander gate: trim gain, per-channel peak envelope,
// fourth-power expander below threshold and slewed gate gain per sample.
//
// Channels: in_* takes a sample (tdata) with its channel number (tuser);
// out_* returns the gated sample with the same channel number. cfg_* writes
// one of five registers (trim, threshold, attack, release, slew) by index;
// cfg_ready is always high and writes are meant for an idle block.
// Processing: the path to a valid result is longer when the envelope is
// below threshold, as the 24-step restoring divide that forms
// envelope/threshold runs only then. The block handles one sample at a time
// and takes no new sample before the last result is in the output register;
// the shared 26x26 multiplier and the divider set that.
// The result sits in an output register: the next sample is taken while a
// result still waits, and a stalled receiver holds the block only at the
// final step, before the next result overwrites the register.
// Reset (rst_n low, synchronous) restores register defaults and clears
// both channel envelopes and gate gains to zero.
module slewed_downward_expander_gate
  import sdeg_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [TW-1:0]           in_tdata,   // [SAMPLE_BITS-1:0] sample_in
  input  logic [0:0]              in_tuser,   // [0] chan
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [TW-1:0]           out_tdata,  // [SAMPLE_BITS-1:0] sample_out
  output logic [0:0]              out_tuser,  // [0] chan_out
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  op_t                           cmd;
  sdeg_sts_t                     sts;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  sdeg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sdeg_dp #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_chan    (in_tuser[0]),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_chan   (out_tuser[0]),
    .out_sample (out_sample)
  );

  assign out_tdata = TW'(unsigned'(out_sample));

endmodule

// ----- tb/sv/sdeg_gate_checker.sv -----
// Channel monitor for the slewed downward expander gate: mirrors register
// writes, predicts each gated sample and compares it with the out_* transfers.
// Depends on sdeg_pkg for register indexes and field widths.
module sdeg_gate_checker
  import sdeg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [SAMPLE_BITS_DEF-1:0] in_tdata,   // [23:0] sample_in
  input  logic [0:0]                 in_tuser,   // [0] chan
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [SAMPLE_BITS_DEF-1:0] out_tdata,  // [23:0] sample_out
  input  logic [0:0]                 out_tuser,  // [0] chan_out
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]        cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         checked
);

  localparam int SB = SAMPLE_BITS_DEF;
  localparam logic [63:0] HALF_Q  = 64'd1 << (FRAC - 1);
  localparam logic [63:0] UNITY_Q = 64'd1 << FRAC;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -(64'sd1 <<< (SB - 1));

  typedef struct packed {
    logic [0:0]    chan;
    logic [SB-1:0] sample;
  } gated_t;

  logic [TRIM_W-1:0] trim_r;
  logic [THR_W-1:0]  thr_r;
  logic [COEF_W-1:0] attack_r;
  logic [COEF_W-1:0] release_r;
  logic [COEF_W-1:0] slew_r;
  logic [SB-1:0]     env_st  [CHANNELS_DEF];
  logic [GAIN_W-1:0] gain_st [CHANNELS_DEF];
  gated_t            gated_q [$];

  // One-pole move toward goal, rounded step, never past the goal.
  function automatic logic [63:0] follow(logic [63:0] cur, logic [63:0] goal,
                                         logic [63:0] coef);
    if (goal >= cur) return cur + ((coef * (goal - cur) + HALF_Q) >> FRAC);
    return cur - ((coef * (cur - goal) + HALF_Q) >> FRAC);
  endfunction

  function automatic logic signed [63:0] clip(logic signed [63:0] v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // Advance the channel's envelope and gate gain, return the gated sample.
  function automatic gated_t gate_sample(logic [0:0] ch, logic [SB-1:0] raw);
    logic signed [63:0] s;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [63:0] mag, env, thr, tgt, gg, r, r2;
    int idx;
    idx = int'(ch) % CHANNELS_DEF;
    s = $signed(raw);
    x = clip((s * $signed({48'd0, trim_r}) + 64'sd2048) >>> TRIM_FRAC);
    mag = (x < 0) ? 64'(-x) : 64'(x);
    env = follow(64'(env_st[idx]), mag, (mag > 64'(env_st[idx])) ? attack_r : release_r);
    env_st[idx] = env[SB-1:0];
    thr = (thr_r == '0) ? 64'd1 : 64'(thr_r);
    if (env >= thr) begin
      tgt = UNITY_Q;
    end else begin
      r   = (env << FRAC) / thr;
      r2  = (r * r + HALF_Q) >> FRAC;
      tgt = (r2 * r2 + HALF_Q) >> FRAC;
    end
    gg = follow(64'(gain_st[idx]), tgt, 64'(slew_r));
    gain_st[idx] = gg[GAIN_W-1:0];
    y = clip((x * $signed(gg) + $signed(HALF_Q)) >>> FRAC);
    return '{chan: ch, sample: y[SB-1:0]};
  endfunction

  always @(posedge clk) begin
    gated_t want;
    if (!rst_n) begin
      trim_r    = TRIM_RST;
      thr_r     = THR_RST;
      attack_r  = ATTACK_RST;
      release_r = RELEASE_RST;
      slew_r    = SLEW_RST;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        env_st[i]  = '0;
        gain_st[i] = '0;
      end
      gated_q.delete();
      errors  <= 0;
      checked <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRIM:    trim_r    = cfg_data[TRIM_W-1:0];
          REG_THR:     thr_r     = cfg_data[THR_W-1:0];
          REG_ATTACK:  attack_r  = cfg_data[COEF_W-1:0];
          REG_RELEASE: release_r = cfg_data[COEF_W-1:0];
          REG_SLEW:    slew_r    = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      // Results leave only after their sample is processed: match first.
      if (out_tvalid && out_tready) begin
        checked <= checked + 1;
        if (gated_q.size() == 0) begin
          if (errors < 10)
            $display("ERROR: result chan %0d sample %h with nothing outstanding",
                     out_tuser, out_tdata);
          errors <= errors + 1;
        end else begin
          want = gated_q.pop_front();
          if (want.chan !== out_tuser || want.sample !== out_tdata) begin
            if (errors < 10)
              $display("ERROR: result %0d expected chan %0d sample %h, got chan %0d sample %h",
                       checked, want.chan, want.sample, out_tuser, out_tdata);
            errors <= errors + 1;
          end
        end
      end
      // Append the prediction at the tail of the queue.
      if (in_tvalid && in_tready)
        gated_q = {gated_q, gate_sample(in_tuser, in_tdata)};
      pending <= gated_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_slewed_downward_expander_gate.sv -----
// Top of the gate testbench: clock, reset, register programming and sample
// streams with random idling; verdict from sdeg_gate_checker's error count.
// Depends on sdeg_pkg, slewed_downward_expander_gate and sdeg_gate_checker.
module tb_slewed_downward_expander_gate;
  import sdeg_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 60;
  // Indexes past the register list: writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [SB-1:0]           in_tdata;   // [23:0] sample_in
  logic [0:0]              in_tuser;   // [0] chan
  logic                    out_tvalid;
  logic                    out_tready;
  logic [SB-1:0]           out_tdata;  // [23:0] sample_out
  logic [0:0]              out_tuser;  // [0] chan_out
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  int errors, pending, checked;
  int in_gap_pct, out_gap_pct;
  int unsigned thr_now;
  int samples_sent, settings_used, quiet;

  slewed_downward_expander_gate dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  sdeg_gate_checker u_gate_chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .pending, .checked
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_gap_pct);
  end

  // End the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 quiet, pending);
        $display("tb_slewed_downward_expander_gate: errors");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [0:0] ch, logic [SB-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= ch;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_THR) thr_now = (val[THR_W-1:0] == 0) ? 1 : val[THR_W-1:0];
  endtask

  task automatic program_gate(int unsigned trim, int unsigned thr, int unsigned atk,
                              int unsigned rel, int unsigned slew);
    drain();
    write_reg(REG_TRIM, trim);
    write_reg(REG_THR, thr);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_SLEW, slew);
    settings_used++;
  endtask

  function automatic logic [SB-1:0] within_amp(int unsigned amp);
    int v;
    if (amp > 8388607) amp = 8388607;
    v = int'($urandom_range(2 * amp)) - int'(amp);
    return v[SB-1:0];
  endfunction

  // Bursts of one character each: full-scale noise, loud noise, levels
  // around the threshold, quiet, silence, rail to rail.
  task automatic play_bursts(int count);
    int kind, len, done;
    int unsigned amp;
    logic [SB-1:0] s;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(5);
      len  = $urandom_range(8, 40);
      case (kind)
        1: amp = $urandom_range(8388607, 1048576);
        2: amp = thr_now * $urandom_range(30, 3) / 10;
        3: amp = $urandom_range(63);
        default: amp = 0;
      endcase
      for (int i = 0; i < len && done < count; i++) begin
        case (kind)
          0: s = SB'($urandom());
          4: s = '0;
          5: s = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
          default: s = within_amp(amp);
        endcase
        send_sample(1'($urandom_range(1)), s);
        done++;
      end
    end
  endtask

  initial begin
    logic [SB-1:0] edge_vals [8];
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_TRIM;
    cfg_data     = '0;
    in_gap_pct   = 37;
    out_gap_pct  = 37;
    thr_now      = THR_RST;
    samples_sent = 0;
    settings_used = 1;
    quiet        = 0;
    edge_vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                  24'h000001, 24'h555555, 24'hAAAAAA, 24'h800000};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Edge values on both channels at the reset settings; the full negative
    // sample at unity trim keeps its exact magnitude.
    foreach (edge_vals[i]) begin
      send_sample(1'b0, edge_vals[i]);
      send_sample(1'b1, edge_vals[i]);
    end
    drain();
    write_reg(IDX_SPARE_LO, 24'hFFFFFF);
    write_reg(IDX_SPARE_HI, 24'h000000);
    send_sample(1'b0, 24'h7FFFFF);
    send_sample(1'b1, 24'h800000);
    play_bursts(200);

    // Every register at its top value: saturating trim, instant tracking.
    program_gate(16'hFFFF, 23'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    play_bursts(220);

    // Bottom values: zero trim, unit threshold, slowest coefficients.
    program_gate(0, 1, 1, 1, 1);
    play_bursts(100);

    // Zero threshold counts as one; zero envelope coefficients freeze it.
    program_gate(4096, 0, 0, 0, $urandom_range(24'hFFFFFF, 24'h400000));
    play_bursts(140);

    // Fast random coefficients so the gate opens and closes often.
    program_gate($urandom_range(16'hFFFF, 2048), $urandom_range(23'h100000, 1),
                 $urandom_range(24'hFFFFFF, 24'h100000),
                 $urandom_range(24'hFFFFFF, 24'h40000),
                 $urandom_range(24'hFFFFFF, 24'h100000));
    play_bursts(300);

    // Fully random settings with no idling on either side.
    program_gate($urandom_range(16'hFFFF), $urandom_range(23'h7FFFFF),
                 $urandom(), $urandom(), $urandom());
    in_gap_pct  = 0;
    out_gap_pct = 0;
    play_bursts(200);
    in_gap_pct  = 37;
    out_gap_pct = 37;

    // Double trim, reset-like envelope times, fast slew.
    program_gate(8192, THR_RST, ATTACK_RST, RELEASE_RST, 24'h200000);
    play_bursts(280);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("sent %0d samples across %0d register settings, %0d gated results compared",
             samples_sent, settings_used, checked);
    $display("covered rail and zero samples, frozen and instant tracking, zero threshold");
    if (errors == 0 && pending == 0) begin
      $display("tb_slewed_downward_expander_gate: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending);
      $display("tb_slewed_downward_expander_gate: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sdeg_pkg.sv
sv/sdeg_ctrl.sv
sv/sdeg_dp.sv
sv/slewed_downward_expander_gate.sv
tb/sv/sdeg_gate_checker.sv
tb/sv/tb_slewed_downward_expander_gate.sv
